// File: rtl/pvo_pkg.sv
// pvo_pkg: constants, register codes and the multiplier request/response types
// for the three-axis position/velocity observer. No dependencies.
`timescale 1ns / 1ps

package pvo_pkg;

  // axes that keep state, and axes that have fields on the ports
  localparam int AXIS_COUNT = 3;
  localparam int PORT_AXES  = 3;

  // signed fixed point, 16 fraction bits
  localparam int VAL_W  = 32;
  localparam int FRAC_W = 16;

  // gains enter the multiplier zero-extended to the widest register
  localparam int STEP_W  = 16;
  localparam int PGAIN_W = 17;
  localparam int VGAIN_W = 24;
  localparam int GAIN_W  = VGAIN_W;

  // serial multiplier: one gain digit per cycle, least significant first
  localparam int DIGIT_W   = 4;
  localparam int DIGITS    = GAIN_W / DIGIT_W;
  localparam int DIG_CNT_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam int PROD_W    = VAL_W + DIGIT_W;
  localparam int RND_W     = VAL_W + GAIN_W - FRAC_W;

  localparam int AX_CNT_W = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;

  localparam int IN_W  = PORT_AXES * VAL_W;
  localparam int OUT_W = 2 * PORT_AXES * VAL_W;

  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  // configuration port
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = VGAIN_W;

  typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;

  localparam cfg_addr_t CFG_STEP_TIME = 2'd0;
  localparam cfg_addr_t CFG_POS_GAIN  = 2'd1;
  localparam cfg_addr_t CFG_VEL_GAIN  = 2'd2;

  localparam logic [STEP_W-1:0]  STEP_RST  = 16'd655;
  localparam logic [PGAIN_W-1:0] PGAIN_RST = 17'd32768;
  localparam logic [VGAIN_W-1:0] VGAIN_RST = 24'd65536;

  typedef struct packed {
    logic                    start;
    logic signed [VAL_W-1:0] a;
    logic [GAIN_W-1:0]       g;
  } pvo_mul_req_t;

  typedef struct packed {
    logic                    busy;
    logic                    done;
    logic signed [VAL_W-1:0] p;
  } pvo_mul_rsp_t;

endpackage

// File: rtl/pvo_mul.sv
// pvo_mul: digit-serial signed value times unsigned gain, scaled by 2^-16 with
// magnitude rounding half away from zero and saturation. Depends on pvo_pkg.
`timescale 1ns / 1ps

module pvo_mul import pvo_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  pvo_mul_req_t req_i,
  output pvo_mul_rsp_t rsp_o
);

  localparam logic [RND_W-1:0] POS_LIM  = {{(RND_W-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}};
  localparam logic [RND_W-1:0] NEG_LIM  = {{(RND_W-VAL_W){1'b0}}, 1'b1, {(VAL_W-1){1'b0}}};
  localparam logic [VAL_W-1:0] RND_HALF = {{(VAL_W-FRAC_W){1'b0}}, 1'b1, {(FRAC_W-1){1'b0}}};

  logic                    busy_q;
  logic                    fin_q;
  logic                    done_q;
  logic [DIG_CNT_W-1:0]    cnt_q;
  logic                    neg_q;
  logic [VAL_W-1:0]        mag_q;
  logic [GAIN_W-1:0]       g_q;
  logic [VAL_W-1:0]        acc_q;
  logic [GAIN_W-1:0]       low_q;
  logic signed [VAL_W-1:0] p_q;

  logic [PROD_W-1:0]       part;
  logic [PROD_W-1:0]       sum;
  logic [RND_W-1:0]        rnd;
  logic signed [VAL_W-1:0] p_d;

  // one digit of the gain times the magnitude, added to the running upper part
  assign part = PROD_W'(mag_q) * PROD_W'(g_q[DIGIT_W-1:0]);
  assign sum  = PROD_W'(acc_q) + part;

  // product already carries the rounding half, drop the fraction bits
  assign rnd = {acc_q, low_q[GAIN_W-1:FRAC_W]};

  always_comb begin
    if (neg_q) begin
      if (rnd > NEG_LIM) begin
        p_d = VAL_MIN;
      end else begin
        p_d = -$signed(rnd[VAL_W-1:0]);
      end
    end else begin
      if (rnd > POS_LIM) begin
        p_d = VAL_MAX;
      end else begin
        p_d = $signed(rnd[VAL_W-1:0]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= fin_q;
      fin_q  <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DIG_CNT_W'(DIGITS - 1)) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      neg_q <= req_i.a[VAL_W-1];
      mag_q <= req_i.a[VAL_W-1] ? (~$unsigned(req_i.a) + 1'b1) : $unsigned(req_i.a);
      g_q   <= req_i.g;
      acc_q <= RND_HALF;
    end else if (busy_q) begin
      acc_q <= sum[PROD_W-1:DIGIT_W];
      low_q <= {sum[DIGIT_W-1:0], low_q[GAIN_W-1:DIGIT_W]};
      g_q   <= g_q >> DIGIT_W;
    end
    if (fin_q) begin
      p_q <= p_d;
    end
  end

  assign rsp_o.busy = busy_q | fin_q;
  assign rsp_o.done = done_q;
  assign rsp_o.p    = p_q;

endmodule

// File: rtl/position_velocity_observer.sv
// position_velocity_observer: three-axis alpha-beta tracker, top level; uses pvo_pkg, pvo_mul
// items are taken only in the idle state, so one item is in work at a time
// each axis runs three products through one shared multiplier that takes a 4-bit gain
//   digit per cycle (6 digits a product)
// reset: rst_ni asynchronous, clears estimates to zero and loads the register defaults
`timescale 1ns / 1ps

module position_velocity_observer import pvo_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration writes, no read-back
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // measured positions
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_W-1:0]       s_axis_tdata,  // meas_x, meas_y, meas_z
  // updated estimates
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_W-1:0]      m_axis_tdata   // est_pos_x/y/z, est_vel_x/y/z
);

  // one-hot sequencer, one pass of MUL_V..MUL_G per axis
  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_MUL_V = 7'b0000010,  // step_time * vel
    ST_PRED  = 7'b0000100,  // pred = pos + step_time * vel
    ST_RESID = 7'b0001000,  // res = meas - pred
    ST_MUL_P = 7'b0010000,  // position_gain * res
    ST_MUL_G = 7'b0100000,  // velocity_gain * res, then write back
    ST_DONE  = 7'b1000000   // hand the item to the output register
  } state_e;

  state_e                  state_q, state_d;
  logic                    go_q, go_d;
  logic [AX_CNT_W-1:0]     axis_q, axis_d;
  logic                    step_axis;
  logic                    load_out;
  logic                    m_valid_q;

  logic [STEP_W-1:0]       step_q;
  logic [PGAIN_W-1:0]      pgain_q;
  logic [VGAIN_W-1:0]      vgain_q;

  // estimates and measurements rotate so that entry 0 is always the axis in work;
  // after the last axis they are back in order and the estimates are the result
  logic signed [VAL_W-1:0] pos_q  [AXIS_COUNT];
  logic signed [VAL_W-1:0] vel_q  [AXIS_COUNT];
  logic signed [VAL_W-1:0] meas_q [AXIS_COUNT];

  logic signed [VAL_W-1:0] m_q;
  logic signed [VAL_W-1:0] pred_q;
  logic signed [VAL_W-1:0] res_q;
  logic signed [VAL_W-1:0] pos_new;
  logic signed [VAL_W-1:0] vel_new;

  logic [OUT_W-1:0]        out_q, out_d;

  pvo_mul_req_t            mul_req;
  pvo_mul_rsp_t            mul_rsp;

  // add or subtract with clamp to the value range
  function automatic logic signed [VAL_W-1:0] sat_add(
    input logic signed [VAL_W-1:0] a,
    input logic signed [VAL_W-1:0] b,
    input logic                    sub
  );
    logic [VAL_W:0] s;
    if (sub) begin
      s = {a[VAL_W-1], a} - {b[VAL_W-1], b};
    end else begin
      s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
    end
    if (s[VAL_W] != s[VAL_W-1]) begin
      sat_add = s[VAL_W] ? VAL_MIN : VAL_MAX;
    end else begin
      sat_add = $signed(s[VAL_W-1:0]);
    end
  endfunction

  // configuration registers, writes to unknown indexes fall through
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= STEP_RST;
      pgain_q <= PGAIN_RST;
      vgain_q <= VGAIN_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_STEP_TIME: step_q  <= cfg_data_i[STEP_W-1:0];
        CFG_POS_GAIN:  pgain_q <= cfg_data_i[PGAIN_W-1:0];
        CFG_VEL_GAIN:  vgain_q <= cfg_data_i[VGAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // shared multiplier, operands picked by the phase that starts it
  always_comb begin
    mul_req.start = go_q;
    mul_req.a     = (state_q == ST_MUL_V) ? vel_q[0] : res_q;
    case (state_q)
      ST_MUL_V: mul_req.g = GAIN_W'(step_q);
      ST_MUL_P: mul_req.g = GAIN_W'(pgain_q);
      default:  mul_req.g = vgain_q;
    endcase
  end

  pvo_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  // sequencer
  always_comb begin
    state_d   = state_q;
    go_d      = 1'b0;
    axis_d    = axis_q;
    step_axis = 1'b0;
    load_out  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = ST_MUL_V;
          go_d    = 1'b1;
          axis_d  = '0;
        end
      end
      ST_MUL_V: begin
        if (mul_rsp.done) begin
          state_d = ST_PRED;
        end
      end
      ST_PRED: begin
        state_d = ST_RESID;
      end
      ST_RESID: begin
        state_d = ST_MUL_P;
        go_d    = 1'b1;
      end
      ST_MUL_P: begin
        if (mul_rsp.done) begin
          state_d = ST_MUL_G;
          go_d    = 1'b1;
        end
      end
      ST_MUL_G: begin
        if (mul_rsp.done) begin
          step_axis = 1'b1;
          if (axis_q == AX_CNT_W'(AXIS_COUNT - 1)) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_MUL_V;
            go_d    = 1'b1;
            axis_d  = axis_q + 1'b1;
          end
        end
      end
      ST_DONE: begin
        // the output register may still hold the previous item
        if (!m_valid_q || m_axis_tready) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      go_q      <= 1'b0;
      axis_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      go_q    <= go_d;
      axis_q  <= axis_d;
      if (load_out) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // write-back values for the axis in work
  assign pos_new = sat_add(pred_q, m_q, 1'b0);
  assign vel_new = sat_add(vel_q[0], mul_rsp.p, 1'b0);

  // estimates, cleared at reset, rotated by one axis per pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < AXIS_COUNT; a++) begin
        pos_q[a] <= '0;
        vel_q[a] <= '0;
      end
    end else if (step_axis) begin
      for (int a = 0; a < AXIS_COUNT - 1; a++) begin
        pos_q[a] <= pos_q[a+1];
        vel_q[a] <= vel_q[a+1];
      end
      pos_q[AXIS_COUNT-1] <= pos_new;
      vel_q[AXIS_COUNT-1] <= vel_new;
    end
  end

  // per-item working values
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      for (int a = 0; a < AXIS_COUNT; a++) begin
        meas_q[a] <= $signed(s_axis_tdata[a*VAL_W +: VAL_W]);
      end
    end else if (step_axis) begin
      for (int a = 0; a < AXIS_COUNT - 1; a++) begin
        meas_q[a] <= meas_q[a+1];
      end
      meas_q[AXIS_COUNT-1] <= meas_q[0];
    end
    // step product first, position correction second
    if (mul_rsp.done) begin
      m_q <= mul_rsp.p;
    end
    if (state_q == ST_PRED) begin
      pred_q <= sat_add(pos_q[0], m_q, 1'b0);
    end
    if (state_q == ST_RESID) begin
      res_q <= sat_add(meas_q[0], pred_q, 1'b1);
    end
    if (load_out) begin
      out_q <= out_d;
    end
  end

  // result packing, axes without state read as zero
  always_comb begin
    out_d = '0;
    for (int a = 0; a < PORT_AXES; a++) begin
      if (a < AXIS_COUNT) begin
        out_d[a*VAL_W +: VAL_W]               = pos_q[a];
        out_d[(PORT_AXES+a)*VAL_W +: VAL_W]   = vel_q[a];
      end
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = out_q;

`ifndef ASSERT_OFF
  // a product only comes back to a phase that asked for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_rsp.done |-> (state_q == ST_MUL_V || state_q == ST_MUL_P || state_q == ST_MUL_G))
    else $error("multiplier result outside a multiply phase");

  // an accepted item starts the velocity product at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> (go_q && state_q == ST_MUL_V))
    else $error("accepted item did not start the multiplier");

  // taking a new item while the multiplier runs would corrupt it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !mul_rsp.busy)
    else $error("input ready while multiplier busy");

  // a finished item waits while the output register is still held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && m_axis_tvalid && !m_axis_tready)
      |=> (state_q == ST_DONE && $stable(m_axis_tdata)))
    else $error("output register overwritten before it was taken");
`endif

endmodule
